// File: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// types and constants shared by the i2c master bit engine
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  // command codes carried in the mode field
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_STOP  = 3'd2;
  localparam logic [2:0] MODE_WRITE = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_TICKS_PER_US   = 3'd0;
  localparam logic [2:0] REG_HALF_BIT_US    = 3'd1;
  localparam logic [2:0] REG_START_STOP_US  = 3'd2;
  localparam logic [2:0] REG_ACK_HALF_US    = 3'd3;
  localparam logic [2:0] REG_ACK_POLL_LIMIT = 3'd4;

  // reset values of the configuration registers
  localparam logic [7:0] RST_TICKS_PER_US   = 8'd100;
  localparam logic [7:0] RST_HALF_BIT_US    = 8'd5;
  localparam logic [7:0] RST_START_STOP_US  = 8'd4;
  localparam logic [7:0] RST_ACK_HALF_US    = 8'd2;
  localparam logic [7:0] RST_ACK_POLL_LIMIT = 8'd250;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_A,
    PH_ST_B,
    PH_SP_A,
    PH_SP_B,
    PH_W_LOW,
    PH_W_HIGH,
    PH_K_A,
    PH_K_B,
    PH_K_POLL,
    PH_R_LOW,
    PH_R_HIGH,
    PH_M_LOW,
    PH_M_HIGH
  } phase_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       stop_after;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } res_t;

  typedef struct packed {
    logic [7:0] ticks_per_us;
    logic [7:0] half_bit_us;
    logic [7:0] start_stop_us;
    logic [7:0] ack_half_us;
    logic [7:0] ack_poll_limit;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/i2cm_cfg_regs.sv
// ----------------------------------------------------------------------------
// i2cm_cfg_regs
// timing configuration registers, written through a plain index/data port
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [7:0]    cfg_data,
  output i2cm_pkg::cfg_t     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_us   <= i2cm_pkg::RST_TICKS_PER_US;
      cfg.half_bit_us    <= i2cm_pkg::RST_HALF_BIT_US;
      cfg.start_stop_us  <= i2cm_pkg::RST_START_STOP_US;
      cfg.ack_half_us    <= i2cm_pkg::RST_ACK_HALF_US;
      cfg.ack_poll_limit <= i2cm_pkg::RST_ACK_POLL_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cm_pkg::REG_TICKS_PER_US:   cfg.ticks_per_us   <= cfg_data;
        i2cm_pkg::REG_HALF_BIT_US:    cfg.half_bit_us    <= cfg_data;
        i2cm_pkg::REG_START_STOP_US:  cfg.start_stop_us  <= cfg_data;
        i2cm_pkg::REG_ACK_HALF_US:    cfg.ack_half_us    <= cfg_data;
        i2cm_pkg::REG_ACK_POLL_LIMIT: cfg.ack_poll_limit <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/i2cm_engine.sv
// ----------------------------------------------------------------------------
// i2cm_engine
// bus sequencer: advances one tick per step and forms the result of that tick
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  i2cm_pkg::cmd_t      cmd,
  input  i2cm_pkg::cfg_t      cfg,
  output i2cm_pkg::res_t      res
);

  i2cm_pkg::phase_t phase, phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] us_prescale, us_prescale_next;
  logic [7:0] us_count, us_count_next;
  logic [7:0] poll_count, poll_count_next;
  logic [7:0] rx_last, rx_last_next;
  logic       pending_stop, pending_stop_next;
  logic       ack_choice, ack_choice_next;
  logic       ack_missing_flag, ack_missing_flag_next;
  logic       scl_reg, scl_reg_next;
  logic       sda_reg, sda_reg_next;
  logic       sda_oe_reg, sda_oe_reg_next;
  logic       done_now;

  // shared microsecond timer
  logic [7:0] phase_us, tpu, n_us, pre_inc, cnt_inc, pre_t, cnt_t;
  logic       pre_wrap, elapsed;
  logic [3:0] bit_inc;

  always_comb begin
    case (phase)
      i2cm_pkg::PH_ST_A, i2cm_pkg::PH_ST_B,
      i2cm_pkg::PH_SP_A, i2cm_pkg::PH_SP_B:   phase_us = cfg.start_stop_us;
      i2cm_pkg::PH_W_LOW, i2cm_pkg::PH_W_HIGH,
      i2cm_pkg::PH_R_LOW, i2cm_pkg::PH_R_HIGH: phase_us = cfg.half_bit_us;
      i2cm_pkg::PH_M_LOW, i2cm_pkg::PH_M_HIGH: phase_us = cfg.ack_half_us;
      default:                                 phase_us = 8'd1;
    endcase
    tpu      = (cfg.ticks_per_us == 8'd0) ? 8'd1 : cfg.ticks_per_us;
    n_us     = (phase_us == 8'd0) ? 8'd1 : phase_us;
    pre_inc  = us_prescale + 8'd1;
    pre_wrap = (pre_inc >= tpu);
    cnt_inc  = pre_wrap ? (us_count + 8'd1) : us_count;
    elapsed  = (cnt_inc >= n_us);
    pre_t    = (elapsed || pre_wrap) ? 8'd0 : pre_inc;
    cnt_t    = elapsed ? 8'd0 : cnt_inc;
    bit_inc  = bit_count + 4'd1;
  end

  always_comb begin
    phase_next            = phase;
    bit_count_next        = bit_count;
    shift_reg_next        = shift_reg;
    us_prescale_next      = us_prescale;
    us_count_next         = us_count;
    poll_count_next       = poll_count;
    rx_last_next          = rx_last;
    pending_stop_next     = pending_stop;
    ack_choice_next       = ack_choice;
    ack_missing_flag_next = ack_missing_flag;
    scl_reg_next          = scl_reg;
    sda_reg_next          = sda_reg;
    sda_oe_reg_next       = sda_oe_reg;
    done_now              = 1'b0;

    if (phase == i2cm_pkg::PH_IDLE) begin
      us_prescale_next = 8'd0;
      us_count_next    = 8'd0;
      case (cmd.mode)
        i2cm_pkg::MODE_START: begin
          sda_oe_reg_next = 1'b1;
          sda_reg_next    = 1'b1;
          scl_reg_next    = 1'b1;
          phase_next      = i2cm_pkg::PH_ST_A;
        end
        i2cm_pkg::MODE_STOP: begin
          sda_oe_reg_next = 1'b1;
          sda_reg_next    = 1'b0;
          scl_reg_next    = 1'b0;
          phase_next      = i2cm_pkg::PH_SP_A;
        end
        i2cm_pkg::MODE_WRITE: begin
          sda_oe_reg_next       = 1'b1;
          scl_reg_next          = 1'b0;
          shift_reg_next        = cmd.tx_byte;
          bit_count_next        = 4'd0;
          pending_stop_next     = cmd.stop_after;
          ack_missing_flag_next = 1'b0;
          sda_reg_next          = cmd.tx_byte[7];
          phase_next            = i2cm_pkg::PH_W_LOW;
        end
        i2cm_pkg::MODE_READ: begin
          sda_oe_reg_next = 1'b0;
          sda_reg_next    = 1'b1;
          scl_reg_next    = 1'b0;
          shift_reg_next  = 8'd0;
          bit_count_next  = 4'd0;
          ack_choice_next = cmd.send_ack;
          phase_next      = i2cm_pkg::PH_R_LOW;
        end
        default: ;
      endcase
    end else begin
      // timed phases take the timer update; the poll phase does not advance it
      if (phase != i2cm_pkg::PH_K_POLL) begin
        us_prescale_next = pre_t;
        us_count_next    = cnt_t;
      end
      case (phase)
        i2cm_pkg::PH_ST_A: if (elapsed) begin
          sda_reg_next = 1'b0;
          phase_next   = i2cm_pkg::PH_ST_B;
        end
        i2cm_pkg::PH_ST_B: if (elapsed) begin
          scl_reg_next = 1'b0;
          phase_next   = i2cm_pkg::PH_IDLE;
          done_now     = 1'b1;
        end
        i2cm_pkg::PH_SP_A: if (elapsed) begin
          scl_reg_next = 1'b1;
          sda_reg_next = 1'b1;
          phase_next   = i2cm_pkg::PH_SP_B;
        end
        i2cm_pkg::PH_SP_B: if (elapsed) begin
          phase_next = i2cm_pkg::PH_IDLE;
          done_now   = 1'b1;
        end
        i2cm_pkg::PH_W_LOW: if (elapsed) begin
          scl_reg_next = 1'b1;
          phase_next   = i2cm_pkg::PH_W_HIGH;
        end
        i2cm_pkg::PH_W_HIGH: if (elapsed) begin
          scl_reg_next   = 1'b0;
          shift_reg_next = {shift_reg[6:0], 1'b0};
          bit_count_next = bit_inc;
          if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
            sda_oe_reg_next = 1'b0;
            sda_reg_next    = 1'b1;
            phase_next      = i2cm_pkg::PH_K_A;
          end else begin
            sda_reg_next = shift_reg[6];
            phase_next   = i2cm_pkg::PH_W_LOW;
          end
        end
        i2cm_pkg::PH_K_A: if (elapsed) begin
          scl_reg_next = 1'b1;
          phase_next   = i2cm_pkg::PH_K_B;
        end
        i2cm_pkg::PH_K_B: if (elapsed) begin
          poll_count_next = 8'd0;
          phase_next      = i2cm_pkg::PH_K_POLL;
        end
        i2cm_pkg::PH_K_POLL: begin
          if (!cmd.sda_in) begin
            scl_reg_next = 1'b0;
            if (pending_stop) begin
              sda_oe_reg_next  = 1'b1;
              sda_reg_next     = 1'b0;
              us_prescale_next = 8'd0;
              us_count_next    = 8'd0;
              phase_next       = i2cm_pkg::PH_SP_A;
            end else begin
              phase_next = i2cm_pkg::PH_IDLE;
              done_now   = 1'b1;
            end
          end else if (poll_count >= cfg.ack_poll_limit) begin
            ack_missing_flag_next = 1'b1;
            sda_oe_reg_next       = 1'b1;
            scl_reg_next          = 1'b0;
            sda_reg_next          = 1'b0;
            us_prescale_next      = 8'd0;
            us_count_next         = 8'd0;
            phase_next            = i2cm_pkg::PH_SP_A;
          end else begin
            poll_count_next = poll_count + 8'd1;
          end
        end
        i2cm_pkg::PH_R_LOW: if (elapsed) begin
          scl_reg_next = 1'b1;
          phase_next   = i2cm_pkg::PH_R_HIGH;
        end
        i2cm_pkg::PH_R_HIGH: begin
          // sample on the first tick of scl high
          if (us_prescale == 8'd0 && us_count == 8'd0) begin
            shift_reg_next = {shift_reg[6:0], cmd.sda_in};
          end
          if (elapsed) begin
            scl_reg_next   = 1'b0;
            bit_count_next = bit_inc;
            if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
              rx_last_next    = shift_reg_next;
              sda_oe_reg_next = 1'b1;
              sda_reg_next    = !ack_choice;
              phase_next      = i2cm_pkg::PH_M_LOW;
            end else begin
              phase_next = i2cm_pkg::PH_R_LOW;
            end
          end
        end
        i2cm_pkg::PH_M_LOW: if (elapsed) begin
          scl_reg_next = 1'b1;
          phase_next   = i2cm_pkg::PH_M_HIGH;
        end
        i2cm_pkg::PH_M_HIGH: if (elapsed) begin
          scl_reg_next = 1'b0;
          phase_next   = i2cm_pkg::PH_IDLE;
          done_now     = 1'b1;
        end
        default: phase_next = i2cm_pkg::PH_IDLE;
      endcase
    end

    res.scl_level   = scl_reg_next;
    res.sda_level   = sda_oe_reg_next ? sda_reg_next : 1'b1;
    res.sda_drive   = sda_oe_reg_next;
    res.busy_res    = (phase_next != i2cm_pkg::PH_IDLE);
    res.done_res    = done_now;
    res.rx_byte     = rx_last_next;
    res.ack_missing = ack_missing_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= i2cm_pkg::PH_IDLE;
      bit_count        <= 4'd0;
      shift_reg        <= 8'd0;
      us_prescale      <= 8'd0;
      us_count         <= 8'd0;
      poll_count       <= 8'd0;
      rx_last          <= 8'd0;
      pending_stop     <= 1'b0;
      ack_choice       <= 1'b0;
      ack_missing_flag <= 1'b0;
      scl_reg          <= 1'b1;
      sda_reg          <= 1'b1;
      sda_oe_reg       <= 1'b1;
    end else if (step) begin
      phase            <= phase_next;
      bit_count        <= bit_count_next;
      shift_reg        <= shift_reg_next;
      us_prescale      <= us_prescale_next;
      us_count         <= us_count_next;
      poll_count       <= poll_count_next;
      rx_last          <= rx_last_next;
      pending_stop     <= pending_stop_next;
      ack_choice       <= ack_choice_next;
      ack_missing_flag <= ack_missing_flag_next;
      scl_reg          <= scl_reg_next;
      sda_reg          <= sda_reg_next;
      sda_oe_reg       <= sda_oe_reg_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// i2c master waveform generator, one item per bus timer tick
//
//   channel  dir  handshake            payload
//   cmd      in   cmd_valid/cmd_stall  i2cm_pkg::cmd_t (mode, byte, ack, sda)
//   res      out  res_valid/res_stall  i2cm_pkg::res_t (scl, sda, status)
//   cfg      in   cfg_we               cfg_index, cfg_data
//
// one item per cycle sustained while the result is not held; a taken item
// passes the input register, then the sequencer step into the result register
// the sequencer state moves once per item, so idle cycles do not count time
// synchronous reset: timing registers to defaults, bus lines driven high
// cmd_stall rises only while a result waits and res_stall is high
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output      logic          cmd_stall,
  input  i2cm_pkg::cmd_t     cmd,
  output      logic          res_valid,
  input  wire logic          res_stall,
  output i2cm_pkg::res_t     res,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [7:0]    cfg_data
);

  i2cm_pkg::cfg_t cfg;
  i2cm_pkg::cmd_t s1_cmd;
  i2cm_pkg::res_t step_res;
  logic           s1_valid;
  logic           advance;

  // the whole pipe moves unless the result register is held
  assign advance   = !res_valid || !res_stall;
  assign cmd_stall = !advance;

  i2cm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer steps once for each item leaving the input register
  i2cm_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (advance && s1_valid),
    .cmd  (s1_cmd),
    .cfg  (cfg),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= cmd_valid;
      res_valid <= s1_valid;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cmd <= cmd;
      if (s1_valid) begin
        res <= step_res;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// port level checks on the i2c master bit engine
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           cmd_stall,
  input wire logic           res_valid,
  input wire logic           res_stall,
  input i2cm_pkg::res_t      res
);

  // held result stays put
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // input only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> res_valid && res_stall)
    else $error("input stalled without output backpressure");

  // a finished command leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.done_res |-> !res.busy_res)
    else $error("done with busy set");

  // released sda reads high
  a_sda_release: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.sda_drive |-> res.sda_level)
    else $error("released sda not high");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

`default_nettype wire

// File: verif/tb_i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_engine
// self-checking bench for the i2c master bit engine
//
// every command item is one bus timer tick and gives exactly one result item.
// a cycle model of the sequencer runs as items are taken and queues the bus
// levels and status it expects. results are compared field by field in order.
// a directed table covers reset values, extreme and zero timing settings,
// acknowledge found and acknowledge timeout, reads with ack and nack, and
// commands offered while busy. it is followed by random command sequences
// under several small timing settings. both handshakes idle in random bursts,
// and the result side holds off once for a long stretch to back up the input.
// ----------------------------------------------------------------------------

module tb_i2c_master_bit_engine;
  timeunit 1ns;
  timeprecision 1ps;

  // mode codes the engine treats as no command
  localparam logic [2:0] MODE_RSVD_LO = 3'd5;
  localparam logic [2:0] MODE_RSVD_HI = 3'd7;

  localparam logic [7:0] ACK_WAIT_US = 8'd1;  // wait either side of the ack clock
  localparam int SETTLE_CYCLES = 8;            // pipeline is two deep
  localparam int HOLD_CYCLES   = 200;          // long result-side hold-off
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_ITEMS   = 60;
  localparam int NO_SET        = -1;
  localparam int MAX_PRINTS    = 40;

  // sda_in pattern fed while a directed command runs to completion
  typedef enum int {FILL_NONE, FILL_LOW, FILL_HIGH, FILL_RAND} fill_t;
  // how the random target answers the acknowledge poll
  typedef enum int {ACK_FAST, ACK_SLOW, ACK_NONE} ack_style_t;

  typedef struct {
    i2cm_pkg::cmd_t c;
    bit             typed;     // want holds the expected result
    i2cm_pkg::res_t want;
    fill_t          fill;      // FILL_NONE: no ticks added after this row
    int             setting;   // index into dir_setting, applied before the row
  } row_t;

  // dut ports; the inputs are known from time zero
  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           cmd_valid = 1'b0;
  logic           cmd_stall;
  i2cm_pkg::cmd_t cmd       = '0;
  logic           res_valid;
  logic           res_stall = 1'b0;
  i2cm_pkg::res_t res;
  logic           cfg_we    = 1'b0;
  logic [2:0]     cfg_index = i2cm_pkg::REG_TICKS_PER_US;
  logic [7:0]     cfg_data  = 8'd0;

  // bench control
  bit             idle_on  = 1'b1;   // random gaps on both channels
  bit             hold_req = 1'b0;   // ask the result side for one long hold-off
  i2cm_pkg::res_t pending_levels[$]; // expected results, oldest first
  row_t           dir_rows[$];
  i2cm_pkg::cfg_t dir_setting[3];

  int n_errors   = 0;
  int n_items    = 0;
  int n_checked  = 0;
  int n_settings = 0;
  int n_writes   = 0;
  int n_reads    = 0;
  int n_frames   = 0;
  int n_nacks    = 0;

  // sequencer model state, reset values
  i2cm_pkg::cfg_t   cfg_now      = {i2cm_pkg::RST_TICKS_PER_US, i2cm_pkg::RST_HALF_BIT_US,
                                    i2cm_pkg::RST_START_STOP_US, i2cm_pkg::RST_ACK_HALF_US,
                                    i2cm_pkg::RST_ACK_POLL_LIMIT};
  i2cm_pkg::phase_t eng_phase    = i2cm_pkg::PH_IDLE;
  logic [3:0]       bits_done    = 4'd0;
  logic [7:0]       shifter      = 8'd0;
  logic [7:0]       tick_div     = 8'd0;
  logic [7:0]       us_cnt       = 8'd0;
  logic [7:0]       poll_cnt     = 8'd0;
  logic [7:0]       rx_last_byte = 8'd0;
  logic             stop_pending = 1'b0;
  logic             ack_to_send  = 1'b0;
  logic             nack_seen    = 1'b0;
  logic             scl_q        = 1'b1;
  logic             sda_q        = 1'b1;
  logic             sda_oe_q     = 1'b1;
  logic             done_q       = 1'b0;

  i2c_master_bit_engine dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // ---- sequencer model ----------------------------------------------------

  // microsecond timer; zero in a timing register counts as one
  function automatic bit delay_done(input logic [7:0] dly);
    logic [7:0] per_us;
    logic [7:0] span;
    per_us = (cfg_now.ticks_per_us == 8'd0) ? 8'd1 : cfg_now.ticks_per_us;
    span = (dly == 8'd0) ? 8'd1 : dly;
    tick_div = tick_div + 8'd1;
    if (tick_div >= per_us) begin
      tick_div = 8'd0;
      us_cnt = us_cnt + 8'd1;
    end
    if (us_cnt >= span) begin
      us_cnt = 8'd0;
      tick_div = 8'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void begin_stop();
    sda_oe_q = 1'b1;
    scl_q = 1'b0;
    sda_q = 1'b0;
    tick_div = 8'd0;
    us_cnt = 8'd0;
    eng_phase = i2cm_pkg::PH_SP_A;
  endfunction

  function automatic void end_command();
    eng_phase = i2cm_pkg::PH_IDLE;
    done_q = 1'b1;
  endfunction

  // one tick of the engine; returns the levels and status after it
  function automatic i2cm_pkg::res_t step_bus_engine(input i2cm_pkg::cmd_t c);
    i2cm_pkg::res_t r;
    done_q = 1'b0;
    if (eng_phase == i2cm_pkg::PH_IDLE) begin
      // commands are only taken here; any idle tick clears the timer
      tick_div = 8'd0;
      us_cnt = 8'd0;
      case (c.mode)
        i2cm_pkg::MODE_START: begin
          sda_oe_q = 1'b1;
          sda_q = 1'b1;
          scl_q = 1'b1;
          eng_phase = i2cm_pkg::PH_ST_A;
          n_frames++;
        end
        i2cm_pkg::MODE_STOP: begin
          begin_stop();
          n_frames++;
        end
        i2cm_pkg::MODE_WRITE: begin
          sda_oe_q = 1'b1;
          scl_q = 1'b0;
          shifter = c.tx_byte;
          bits_done = 4'd0;
          stop_pending = c.stop_after;
          nack_seen = 1'b0;
          sda_q = c.tx_byte[7];
          eng_phase = i2cm_pkg::PH_W_LOW;
          n_writes++;
        end
        i2cm_pkg::MODE_READ: begin
          sda_oe_q = 1'b0;
          sda_q = 1'b1;
          scl_q = 1'b0;
          shifter = 8'd0;
          bits_done = 4'd0;
          ack_to_send = c.send_ack;
          eng_phase = i2cm_pkg::PH_R_LOW;
          n_reads++;
        end
        default: ;
      endcase
    end else begin
      case (eng_phase)
        i2cm_pkg::PH_ST_A: if (delay_done(cfg_now.start_stop_us)) begin
          sda_q = 1'b0;
          eng_phase = i2cm_pkg::PH_ST_B;
        end
        i2cm_pkg::PH_ST_B: if (delay_done(cfg_now.start_stop_us)) begin
          scl_q = 1'b0;
          end_command();
        end
        i2cm_pkg::PH_SP_A: if (delay_done(cfg_now.start_stop_us)) begin
          scl_q = 1'b1;
          sda_q = 1'b1;
          eng_phase = i2cm_pkg::PH_SP_B;
        end
        i2cm_pkg::PH_SP_B: if (delay_done(cfg_now.start_stop_us)) begin
          end_command();
        end
        i2cm_pkg::PH_W_LOW: if (delay_done(cfg_now.half_bit_us)) begin
          scl_q = 1'b1;
          eng_phase = i2cm_pkg::PH_W_HIGH;
        end
        i2cm_pkg::PH_W_HIGH: if (delay_done(cfg_now.half_bit_us)) begin
          scl_q = 1'b0;
          shifter = shifter << 1;
          bits_done = bits_done + 4'd1;
          if (bits_done >= i2cm_pkg::BITS_PER_BYTE) begin
            // release sda for the target's acknowledge
            sda_oe_q = 1'b0;
            sda_q = 1'b1;
            eng_phase = i2cm_pkg::PH_K_A;
          end else begin
            sda_q = shifter[7];
            eng_phase = i2cm_pkg::PH_W_LOW;
          end
        end
        i2cm_pkg::PH_K_A: if (delay_done(ACK_WAIT_US)) begin
          scl_q = 1'b1;
          eng_phase = i2cm_pkg::PH_K_B;
        end
        i2cm_pkg::PH_K_B: if (delay_done(ACK_WAIT_US)) begin
          poll_cnt = 8'd0;
          eng_phase = i2cm_pkg::PH_K_POLL;
        end
        i2cm_pkg::PH_K_POLL: begin
          if (!c.sda_in) begin
            scl_q = 1'b0;
            if (stop_pending) begin_stop();
            else end_command();
          end else if (poll_cnt >= cfg_now.ack_poll_limit) begin
            // no acknowledge in time: flag it and always stop
            nack_seen = 1'b1;
            n_nacks++;
            begin_stop();
          end else begin
            poll_cnt = poll_cnt + 8'd1;
          end
        end
        i2cm_pkg::PH_R_LOW: if (delay_done(cfg_now.half_bit_us)) begin
          scl_q = 1'b1;
          eng_phase = i2cm_pkg::PH_R_HIGH;
        end
        i2cm_pkg::PH_R_HIGH: begin
          // sample on the first tick after scl rises
          if (tick_div == 8'd0 && us_cnt == 8'd0) shifter = {shifter[6:0], c.sda_in};
          if (delay_done(cfg_now.half_bit_us)) begin
            scl_q = 1'b0;
            bits_done = bits_done + 4'd1;
            if (bits_done >= i2cm_pkg::BITS_PER_BYTE) begin
              rx_last_byte = shifter;
              sda_oe_q = 1'b1;
              sda_q = ~ack_to_send;
              eng_phase = i2cm_pkg::PH_M_LOW;
            end else begin
              eng_phase = i2cm_pkg::PH_R_LOW;
            end
          end
        end
        i2cm_pkg::PH_M_LOW: if (delay_done(cfg_now.ack_half_us)) begin
          scl_q = 1'b1;
          eng_phase = i2cm_pkg::PH_M_HIGH;
        end
        i2cm_pkg::PH_M_HIGH: if (delay_done(cfg_now.ack_half_us)) begin
          scl_q = 1'b0;
          end_command();
        end
        default: eng_phase = i2cm_pkg::PH_IDLE;
      endcase
    end
    r.scl_level   = scl_q;
    r.sda_level   = sda_oe_q ? sda_q : 1'b1;  // released sda reads high
    r.sda_drive   = sda_oe_q;
    r.busy_res    = (eng_phase != i2cm_pkg::PH_IDLE);
    r.done_res    = done_q;
    r.rx_byte     = rx_last_byte;
    r.ack_missing = nack_seen;
    return r;
  endfunction

  // ---- checking -------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    if (n_errors < MAX_PRINTS)
      $display("mismatch at result %0d: %s expected %0h got %0h", n_checked, what, want, got);
    else if (n_errors == MAX_PRINTS)
      $display("further mismatches are counted but not printed");
    n_errors++;
  endtask

  task automatic compare_result(input i2cm_pkg::res_t got);
    i2cm_pkg::res_t want;
    if (pending_levels.size() == 0) begin
      report_mismatch("result with none expected", 16'd0, 16'(got));
      return;
    end
    want = pending_levels.pop_front();
    n_checked++;
    if (got.scl_level !== want.scl_level)
      report_mismatch("scl_level", 16'(want.scl_level), 16'(got.scl_level));
    if (got.sda_level !== want.sda_level)
      report_mismatch("sda_level", 16'(want.sda_level), 16'(got.sda_level));
    if (got.sda_drive !== want.sda_drive)
      report_mismatch("sda_drive", 16'(want.sda_drive), 16'(got.sda_drive));
    if (got.busy_res !== want.busy_res)
      report_mismatch("busy_res", 16'(want.busy_res), 16'(got.busy_res));
    if (got.done_res !== want.done_res)
      report_mismatch("done_res", 16'(want.done_res), 16'(got.done_res));
    if (got.rx_byte !== want.rx_byte)
      report_mismatch("rx_byte", 16'(want.rx_byte), 16'(got.rx_byte));
    if (got.ack_missing !== want.ack_missing)
      report_mismatch("ack_missing", 16'(want.ack_missing), 16'(got.ack_missing));
  endtask

  // result side: check what is taken, then pick the next stall level
  initial begin : result_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) compare_result(res);
      if (stall_left == 0) begin
        if (hold_req) begin
          // long hold-off so the engine backs up and stalls its input
          stall_left = HOLD_CYCLES;
          hold_req = 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
          stall_left = $urandom_range(1, 18);
        end
      end
      if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // ---- stimulus helpers -----------------------------------------------------

  // offer one item, wait until it is taken, then queue its expected result
  task automatic send_item(input i2cm_pkg::cmd_t c, input bit typed,
                           input i2cm_pkg::res_t want);
    i2cm_pkg::res_t calc;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    calc = step_bus_engine(c);
    pending_levels.push_back(typed ? want : calc);
    n_items++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain_results();
    cmd_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all timing registers while the engine and pipeline are quiet
  task automatic apply_setting(input i2cm_pkg::cfg_t s);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= i2cm_pkg::REG_TICKS_PER_US;
    cfg_data <= s.ticks_per_us;
    @(posedge clk);
    cfg_index <= i2cm_pkg::REG_HALF_BIT_US;
    cfg_data <= s.half_bit_us;
    @(posedge clk);
    cfg_index <= i2cm_pkg::REG_START_STOP_US;
    cfg_data <= s.start_stop_us;
    @(posedge clk);
    cfg_index <= i2cm_pkg::REG_ACK_HALF_US;
    cfg_data <= s.ack_half_us;
    @(posedge clk);
    cfg_index <= i2cm_pkg::REG_ACK_POLL_LIMIT;
    cfg_data <= s.ack_poll_limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_now = s;
    n_settings++;
  endtask

  function automatic i2cm_pkg::res_t levels(input bit scl, input bit sda, input bit drv,
                                            input bit busy);
    i2cm_pkg::res_t r;
    r = '0;
    r.scl_level = scl;
    r.sda_level = sda;
    r.sda_drive = drv;
    r.busy_res  = busy;
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] mode, input logic [7:0] tx,
                                  input logic ack, input logic stop, input logic sda,
                                  input bit typed, input i2cm_pkg::res_t want,
                                  input fill_t fill, input int setting);
    row_t r;
    r.c.mode       = mode;
    r.c.tx_byte    = tx;
    r.c.send_ack   = ack;
    r.c.stop_after = stop;
    r.c.sda_in     = sda;
    r.typed        = typed;
    r.want         = want;
    r.fill         = fill;
    r.setting      = setting;
    dir_rows.push_back(r);
  endfunction

  // random command sequences; commands while busy and reserved modes as noise
  task automatic run_random_phase(input int budget, input bit squeeze);
    i2cm_pkg::cmd_t c;
    ack_style_t     sty;
    int             n;
    int             pick;
    n = 0;
    sty = ACK_FAST;
    while (n < budget || eng_phase != i2cm_pkg::PH_IDLE) begin
      c.tx_byte    = 8'($urandom);
      c.send_ack   = 1'($urandom);
      c.stop_after = 1'($urandom);
      c.sda_in     = 1'($urandom);
      if (eng_phase == i2cm_pkg::PH_IDLE) begin
        pick = $urandom_range(0, 19);
        if (pick < 4) c.mode = i2cm_pkg::MODE_START;
        else if (pick < 6) c.mode = i2cm_pkg::MODE_STOP;
        else if (pick < 13) c.mode = i2cm_pkg::MODE_WRITE;
        else if (pick < 18) c.mode = i2cm_pkg::MODE_READ;
        else if (pick == 18) c.mode = i2cm_pkg::MODE_TICK;
        else c.mode = 3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
        sty = ack_style_t'($urandom_range(0, 2));
      end else begin
        c.mode = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                             : i2cm_pkg::MODE_TICK;
        if (eng_phase == i2cm_pkg::PH_K_POLL) begin
          case (sty)
            ACK_FAST: c.sda_in = 1'($urandom);
            ACK_SLOW: c.sda_in = ($urandom_range(0, 7) != 0);
            default:  c.sda_in = 1'b1;
          endcase
        end
      end
      if (squeeze && n == 30) hold_req = 1'b1;
      send_item(c, 1'b0, '0);
      n++;
    end
  endtask

  // ---- main sequence --------------------------------------------------------

  initial begin : stimulus
    i2cm_pkg::cfg_t s;
    i2cm_pkg::cmd_t t;
    int             k;

    // zero acts as one; then poll limit at its top; then prescaler of two
    dir_setting[0] = '0;
    dir_setting[1] = {8'd1, 8'd1, 8'd1, 8'd1, 8'd255};
    dir_setting[2] = {8'd2, 8'd1, 8'd1, 8'd1, 8'd1};

    // register defaults: idle levels and reserved modes
    add_row(i2cm_pkg::MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, levels(1, 1, 1, 0),
            FILL_NONE, NO_SET);
    add_row(MODE_RSVD_LO, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, levels(1, 1, 1, 0),
            FILL_NONE, NO_SET);
    add_row(MODE_RSVD_HI, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, levels(1, 1, 1, 0),
            FILL_NONE, NO_SET);
    // all timing registers zero; first levels of start and stop
    add_row(i2cm_pkg::MODE_START, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, levels(1, 1, 1, 1),
            FILL_RAND, 0);
    add_row(i2cm_pkg::MODE_STOP, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, levels(0, 0, 1, 1),
            FILL_RAND, NO_SET);
    // no acknowledge: a zero poll limit times out on the first high tick
    add_row(i2cm_pkg::MODE_WRITE, 8'hA5, 1'b0, 1'b0, 1'b1, 1'b1, levels(0, 1, 1, 1),
            FILL_HIGH, NO_SET);
    add_row(i2cm_pkg::MODE_READ, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, '0, FILL_RAND, NO_SET);
    // write clears the earlier missing ack
    add_row(i2cm_pkg::MODE_WRITE, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, '0, FILL_LOW, NO_SET);
    add_row(i2cm_pkg::MODE_WRITE, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, '0, FILL_HIGH, NO_SET);
    // read, then commands offered while it is busy are dropped
    add_row(i2cm_pkg::MODE_READ, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, '0, FILL_NONE, NO_SET);
    add_row(i2cm_pkg::MODE_WRITE, 8'h81, 1'b1, 1'b1, 1'b0, 1'b0, '0, FILL_NONE, NO_SET);
    add_row(i2cm_pkg::MODE_START, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, '0, FILL_NONE, NO_SET);
    add_row(i2cm_pkg::MODE_STOP, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0, FILL_NONE, NO_SET);
    add_row(i2cm_pkg::MODE_READ, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, '0, FILL_NONE, NO_SET);
    add_row(MODE_RSVD_HI, 8'h7E, 1'b1, 1'b1, 1'b0, 1'b0, '0, FILL_RAND, NO_SET);
    // poll limit at its top
    add_row(i2cm_pkg::MODE_START, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, '0, FILL_RAND, 1);
    add_row(i2cm_pkg::MODE_WRITE, 8'h5A, 1'b0, 1'b1, 1'b1, 1'b0, '0, FILL_HIGH, NO_SET);
    // prescaler of two, poll limit one
    add_row(i2cm_pkg::MODE_READ, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, '0, FILL_RAND, 2);
    add_row(i2cm_pkg::MODE_WRITE, 8'h3C, 1'b0, 1'b1, 1'b0, 1'b0, '0, FILL_LOW, NO_SET);
    add_row(i2cm_pkg::MODE_STOP, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, '0, FILL_RAND, NO_SET);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table; rows with a fill pattern tick until the command ends
    foreach (dir_rows[i]) begin
      if (dir_rows[i].setting != NO_SET) apply_setting(dir_setting[dir_rows[i].setting]);
      send_item(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);
      if (dir_rows[i].fill != FILL_NONE) begin
        while (eng_phase != i2cm_pkg::PH_IDLE) begin
          t.mode       = i2cm_pkg::MODE_TICK;
          t.tx_byte    = 8'($urandom);
          t.send_ack   = 1'($urandom);
          t.stop_after = 1'($urandom);
          case (dir_rows[i].fill)
            FILL_LOW:  t.sda_in = 1'b0;
            FILL_HIGH: t.sda_in = 1'b1;
            default:   t.sda_in = 1'($urandom);
          endcase
          send_item(t, 1'b0, '0);
        end
      end
    end

    // random part: minimum timing first, then small random settings
    for (k = 0; k < RAND_PHASES; k++) begin
      if (k == 0) begin
        s = {5{8'd1}};
      end else begin
        s.ticks_per_us   = 8'($urandom_range(0, 3));
        s.half_bit_us    = 8'($urandom_range(0, 3));
        s.start_stop_us  = 8'($urandom_range(0, 3));
        s.ack_half_us    = 8'($urandom_range(0, 3));
        s.ack_poll_limit = 8'($urandom_range(0, 6));
      end
      apply_setting(s);
      // last phase runs at full rate on both sides
      if (k == RAND_PHASES - 1) idle_on = 1'b0;
      run_random_phase(PHASE_ITEMS, k == 2);
    end

    drain_results();
    $display("ran %0d tick items, %0d results checked, %0d timing settings",
             n_items, n_checked, n_settings);
    $display("%0d writes (%0d without acknowledge), %0d reads, %0d starts and stops",
             n_writes, n_nacks, n_reads, n_frames);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run-away guard, far beyond the slowest legal run
  initial begin : watchdog
    #50ms;
    $display("timeout with %0d results still expected", pending_levels.size());
    $display("FAIL");
    $finish;
  end

endmodule

// File: i2c_master_bit_engine.f
rtl/i2cm_pkg.sv
rtl/i2cm_cfg_regs.sv
rtl/i2cm_engine.sv
rtl/i2c_master_bit_engine.sv
rtl/i2cm_checker.sv
verif/tb_i2c_master_bit_engine.sv
